FILE: rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// shared widths, field offsets and register map of the lru page replacement
// ----------------------------------------------------------------------------
package lpr_pkg;

    // field widths of one transaction
    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 5;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 5;

    // result tdata layout, lowest bit first
    localparam int OUT_HIT_LSB   = 0;
    localparam int OUT_EVV_LSB   = 1;
    localparam int OUT_EVP_LSB   = 2;
    localparam int OUT_CNT_LSB   = OUT_EVP_LSB + PAGE_W;
    localparam int OUT_FAULT_LSB = OUT_CNT_LSB + COUNT_W;
    localparam int OUT_BITS      = OUT_FAULT_LSB + FAULT_W;
    localparam int OUT_DATA_W    = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = '0;
    localparam logic [CFG_W-1:0]     FRAMES_IN_USE_RST = CFG_W'(16);

endpackage

FILE: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// least recently used page replacement over a recency ordered frame list
// ----------------------------------------------------------------------------
// One page reference per transaction, one result per reference. The block
// takes a new reference every cycle unless the result side stalls: each
// reference is held in the input register, where a parallel compare against
// all resident frames and a one step shift of the recency list update the
// state and load the result register, from which the result is sent.
// The rate is set by that compare and shift across all FRAMES entries. A
// stall on the result side holds the input register and then the input.
// frames_in_use (address 0) limits residency; 0 acts as 1, values above
// FRAMES act as FRAMES. Write it only while no reference is in flight.

module lru_page_replacement
    import lpr_pkg::*;
#(
    parameter int FRAMES     = 16,
    parameter int PAGE_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] page
    input  logic [PAGE_W-1:0]     s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] hit, [1] evicted_valid, [17:2] evicted_page, [22:18] resident_count,
    // [54:23] fault_total, [55] zero
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW    = (PAGE_WIDTH < PAGE_W) ? PAGE_WIDTH : PAGE_W;
    localparam int OCC_W = $clog2(FRAMES + 1);
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // configuration
    logic [CFG_W-1:0] frames_in_use_reg, frames_in_use_next;
    logic             cfg_write;
    logic             cfg_sel;

    // input stage
    logic              in_valid_reg, in_valid_next;
    logic [SW-1:0]     page_reg, page_next;

    // state
    logic [SW-1:0]     rec_reg [FRAMES];
    logic [SW-1:0]     rec_next [FRAMES];
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg, hit_next;
    logic                  evv_reg, evv_next;
    logic [PAGE_W-1:0]     evp_reg, evp_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [FAULT_W-1:0]    ftot_reg, ftot_next;

    // datapath
    logic              fire;
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [IDX_W-1:0]  last_idx;
    logic [OCC_W-1:0]  limit;
    logic              full;

    assign pready    = 1'b1;
    assign cfg_sel   = (paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_sel ? APB_DATA_W'(frames_in_use_reg) : '0;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), ftot_reg, cnt_reg, evp_reg,
                       evv_reg, hit_reg};

    always_comb begin
        if (frames_in_use_reg == '0) begin
            limit = OCC_W'(1);
        end else if (int'(frames_in_use_reg) > FRAMES) begin
            limit = OCC_W'(FRAMES);
        end else begin
            limit = OCC_W'(frames_in_use_reg);
        end
    end

    assign full = (occ_reg >= limit) && (occ_reg != '0);

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (i < int'(occ_reg) && rec_reg[i] == page_reg) begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        frames_in_use_next = frames_in_use_reg;
        if (cfg_write && cfg_sel) begin
            frames_in_use_next = pwdata[CFG_W-1:0];
        end

        in_valid_next = in_valid_reg;
        page_next     = page_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            page_next     = s_tdata[SW-1:0];
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        rec_next   = rec_reg;
        occ_next   = occ_reg;
        fault_next = fault_reg;
        hit_next   = hit_reg;
        evv_next   = evv_reg;
        evp_next   = evp_reg;
        cnt_next   = cnt_reg;
        ftot_next  = ftot_reg;
        last_idx   = '0;

        if (fire) begin
            hit_next = found;
            evv_next = 1'b0;
            evp_next = '0;
            if (found) begin
                last_idx = found_idx;
            end else begin
                if (fault_reg != '1) begin
                    fault_next = fault_reg + FAULT_W'(1);
                end
                if (full) begin
                    evv_next = 1'b1;
                    evp_next = PAGE_W'(rec_reg[IDX_W'(occ_reg - OCC_W'(1))]);
                    last_idx = IDX_W'(occ_reg - OCC_W'(1));
                end else begin
                    last_idx = IDX_W'(occ_reg);
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            for (int i = 1; i < FRAMES; i++) begin
                if (IDX_W'(i) <= last_idx) begin
                    rec_next[i] = rec_reg[i-1];
                end
            end
            rec_next[0] = page_reg;
            cnt_next    = COUNT_W'(occ_next);
            ftot_next   = fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            occ_reg           <= '0;
            fault_reg         <= '0;
        end else begin
            frames_in_use_reg <= frames_in_use_next;
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            occ_reg           <= occ_next;
            fault_reg         <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
        rec_reg  <= rec_next;
        hit_reg  <= hit_next;
        evv_reg  <= evv_next;
        evp_reg  <= evp_next;
        cnt_reg  <= cnt_next;
        ftot_reg <= ftot_next;
    end

endmodule

FILE: rtl/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// port level checks of the lru page replacement
// ----------------------------------------------------------------------------
module lpr_checker
    import lpr_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic                 hit;
    logic                 evv;
    logic [PAGE_W-1:0]    evp;
    logic [COUNT_W-1:0]   cnt;

    assign hit = m_tdata[OUT_HIT_LSB];
    assign evv = m_tdata[OUT_EVV_LSB];
    assign evp = m_tdata[OUT_EVP_LSB +: PAGE_W];
    assign cnt = m_tdata[OUT_CNT_LSB +: COUNT_W];

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(hit && evv))
        else $error("hit transaction reports an eviction");

    // no eviction means a zero page
    a_evp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !evv) |-> (evp == '0))
        else $error("evicted page nonzero without eviction");

    // an eviction leaves frames resident
    a_evict_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && evv) |-> (cnt != '0))
        else $error("eviction with empty residency");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result transaction changed");

    // reset empties the result side
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru page replacement block
// ----------------------------------------------------------------------------
// Page references stream in on the input channel while a local copy of the
// recency list predicts each result. Every result transaction is checked
// field by field. The frame limit steps from its smallest setting up to
// saturation and back down, and the two sides idle at varying rates.
// ----------------------------------------------------------------------------

module testbench;
    import lpr_pkg::*;

    localparam int FRAMES       = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 186;
    localparam int HOT_POOL     = 24;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_IDX_W'(1);

    localparam int IDLE_SENDER_LIGHT = 0;
    localparam int IDLE_SENDER_HEAVY = 1;
    localparam int IDLE_NONE         = 2;

    typedef struct packed {
        logic               hit;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [COUNT_W-1:0] resident;
        logic [FAULT_W-1:0] faults;
    } page_outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PAGE_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [PAGE_W-1:0]  lru_list [FRAMES];
    int unsigned        resident_pages = 0;
    logic [FAULT_W-1:0] fault_total = '0;
    logic [CFG_W-1:0]   frame_setting = FRAMES_IN_USE_RST;

    logic [PAGE_W-1:0] pending_pages [$];
    page_outcome_t     outcome_queue [$];
    logic [PAGE_W-1:0] hot_pages [HOT_POOL];

    int idle_mode = IDLE_SENDER_LIGHT;
    bit page_taken = 1'b0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int result_count = 0;
    int hit_count = 0;
    int eviction_count = 0;
    int setting_count = 0;

    lru_page_replacement uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned frame_limit();
        if (frame_setting == 0) return 1;
        if (frame_setting > FRAMES) return FRAMES;
        return int'(frame_setting);
    endfunction

    function automatic void enqueue_page(input logic [PAGE_W-1:0] pg);
        pending_pages = {pending_pages, pg};
    endfunction

    function automatic void enqueue_outcome(input page_outcome_t res);
        outcome_queue = {outcome_queue, res};
    endfunction

    function automatic page_outcome_t reference_page(input logic [PAGE_W-1:0] pg);
        page_outcome_t res;
        int unsigned   pos;
        int unsigned   last;
        res = '0;
        pos = FRAMES;
        for (int unsigned i = 0; i < resident_pages; i++) begin
            if (pos == FRAMES && lru_list[i] == pg) pos = i;
        end
        if (pos < FRAMES) begin
            res.hit = 1'b1;
            last = pos;
        end else begin
            if (fault_total != '1) fault_total = fault_total + 1;
            if (resident_pages >= frame_limit() && resident_pages > 0) begin
                res.ev_valid = 1'b1;
                res.ev_page  = lru_list[resident_pages-1];
                last = resident_pages - 1;
            end else begin
                last = (resident_pages >= FRAMES) ? FRAMES - 1 : resident_pages;
                if (resident_pages < FRAMES) resident_pages++;
            end
        end
        for (int unsigned i = last; i > 0; i--) lru_list[i] = lru_list[i-1];
        lru_list[0] = pg;
        res.resident = COUNT_W'(resident_pages);
        res.faults   = fault_total;
        return res;
    endfunction

    task automatic note_mismatch(input string field, input logic [FAULT_W-1:0] want,
                                 input logic [FAULT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, result_count, want, got);
    endtask

    // input side: prediction on each accepted transaction
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            page_outcome_t res;
            res = reference_page(pending_pages.pop_front());
            if (res.hit) hit_count++;
            if (res.ev_valid) eviction_count++;
            enqueue_outcome(res);
            page_taken = 1'b1;
        end
    end

    // driver
    always @(negedge aclk) begin
        int gap_pct;
        int stall_pct;
        gap_pct   = (idle_mode == IDLE_SENDER_LIGHT) ? 9  :
                    (idle_mode == IDLE_SENDER_HEAVY) ? 69 : 0;
        stall_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 69 :
                    (idle_mode == IDLE_SENDER_HEAVY) ? 9  : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || page_taken) begin
                if (pending_pages.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pages[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
        page_taken = 1'b0;
    end

    // monitor
    always @(posedge aclk) begin
        page_outcome_t want;
        page_outcome_t got;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            got.hit      = m_tdata[OUT_HIT_LSB];
            got.ev_valid = m_tdata[OUT_EVV_LSB];
            got.ev_page  = m_tdata[OUT_EVP_LSB +: PAGE_W];
            got.resident = m_tdata[OUT_CNT_LSB +: COUNT_W];
            got.faults   = m_tdata[OUT_FAULT_LSB +: FAULT_W];
            if (outcome_queue.size() == 0) begin
                note_mismatch("unexpected transaction", '0, FAULT_W'(got));
            end else begin
                want = outcome_queue.pop_front();
                if (got.hit !== want.hit)
                    note_mismatch("hit", FAULT_W'(want.hit), FAULT_W'(got.hit));
                if (got.ev_valid !== want.ev_valid)
                    note_mismatch("evicted_valid", FAULT_W'(want.ev_valid),
                                  FAULT_W'(got.ev_valid));
                if (got.ev_page !== want.ev_page)
                    note_mismatch("evicted_page", FAULT_W'(want.ev_page),
                                  FAULT_W'(got.ev_page));
                if (got.resident !== want.resident)
                    note_mismatch("resident_count", FAULT_W'(want.resident),
                                  FAULT_W'(got.resident));
                if (got.faults !== want.faults)
                    note_mismatch("fault_total", want.faults, got.faults);
            end
        end
    end

    task automatic drain();
        while (pending_pages.size() != 0 || outcome_queue.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~32'h1f) | APB_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_FRAMES_IN_USE) frame_setting = val;
        setting_count++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_random_pages(input int count);
        int unsigned span;
        span = frame_limit() + 3;
        if (span > HOT_POOL - 1) span = HOT_POOL - 1;
        foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom());
        repeat (count) begin
            if ($urandom_range(0, 99) < 75)
                enqueue_page(hot_pages[$urandom_range(0, span)]);
            else
                enqueue_page(PAGE_W'($urandom()));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings [7];
        settings = '{5'd1, 5'd3, 5'd8, 5'd16, 5'd31, 5'd20, 5'd4};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // limit zero acts as one, unmapped index ignored
        write_register(REG_FRAMES_IN_USE, 5'd0);
        write_register(REG_UNMAPPED, 5'd2);
        pending_pages = '{16'h0000, 16'hffff, 16'hffff, 16'h0000};
        drain();
        write_register(REG_FRAMES_IN_USE, 5'd1);
        enqueue_page(16'h8000);
        drain();
        write_register(REG_FRAMES_IN_USE, 5'd3);
        pending_pages = '{16'h0001, 16'h7fff, 16'h8000, 16'h0001, 16'h7fff};
        drain();
        // limit below occupancy
        write_register(REG_FRAMES_IN_USE, 5'd2);
        pending_pages = '{16'h1234, 16'h1234, 16'h0001};
        drain();

        foreach (settings[p]) begin
            idle_mode = (p < 2) ? IDLE_SENDER_LIGHT : (p < 5) ? IDLE_SENDER_HEAVY : IDLE_NONE;
            write_register(REG_FRAMES_IN_USE, settings[p]);
            queue_random_pages(PHASE_ITEMS);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (outcome_queue.size() != 0) mismatch_count += outcome_queue.size();
        $display("checked %0d results over %0d register writes", result_count, setting_count);
        $display("saw %0d hits, %0d faults, %0d evictions, %0d mismatches",
                 hit_count, fault_total, eviction_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
